FILE: hw/rtl/pi2_pkg.sv
// Package for the polyphase interpolator by two: widths, default sizes,
// sequencer state encoding and the prototype low-pass coefficient table.
// Depends on nothing; used by polyphase_interpolator_by_two_core.
package pi2_pkg;

    // Sample format and output saturation limit
    localparam int SAMPLE_W = 16;
    localparam int SAT_MAX  = 32767;

    // Default sizes
    localparam int TAPS_DEF       = 32;
    localparam int COEF_WIDTH_DEF = 18;

    // Sample digit consumed per multiply cycle
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = SAMPLE_W / DIGIT_W;

    // Prototype table: 32 taps in signed Q2.16
    localparam int ROM_TAPS  = 32;
    localparam int ROM_FRAC  = 16;
    localparam int ROM_WIDTH = 18;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_MAC  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // Blackman-windowed sinc, cutoff 0.25, DC gain 2.0
    localparam logic signed [ROM_WIDTH-1:0] PROTO_ROM [ROM_TAPS] = '{
        18'sd0,      -18'sd8,     18'sd34,     18'sd88,
        -18'sd183,   -18'sd338,   18'sd576,    18'sd930,
        -18'sd1439,  -18'sd2158,  18'sd3171,   18'sd4628,
        -18'sd6840,  -18'sd10614, 18'sd18934,  18'sd58753,
        18'sd58753,  18'sd18934,  -18'sd10614, -18'sd6840,
        18'sd4628,   18'sd3171,   -18'sd2158,  -18'sd1439,
        18'sd930,    18'sd576,    -18'sd338,   -18'sd183,
        18'sd88,     18'sd34,     -18'sd8,     18'sd0
    };

    // Coefficient at index idx, rescaled to coef_w-2 fraction bits.
    // Right shifts round to nearest, ties away from zero; past the table reads zero.
    function automatic logic signed [31:0] coef_at(input int idx, input int coef_w);
        logic signed [31:0] v;
        logic signed [31:0] mag;
        int                 sh;
        v  = 32'sd0;
        sh = (coef_w - 2) - ROM_FRAC;
        if (idx < ROM_TAPS) begin
            v = 32'(PROTO_ROM[idx]);
        end
        if (sh >= 0) begin
            coef_at = v <<< sh;
        end else begin
            mag = (v < 0) ? -v : v;
            mag = (mag + (32'sd1 <<< (-sh - 1))) >>> (-sh);
            coef_at = (v < 0) ? -mag : mag;
        end
    endfunction

endpackage

FILE: hw/rtl/polyphase_interpolator_by_two_core.sv
// An input transaction starts a walk over TAPS/2 taps of the shared even/odd
//   multiplier pair (per tap, one line read, then four 4-bit digits); o_valid rises
//   as the walk finishes and the output is free. No new input is taken until then.
// Reset: synchronous, active low; clears the delay line valid bits (line reads as
//   zero), sets the write pointer to TAPS/2-1 and empties the output register.
// Uses pi2_pkg for widths, state encoding and the coefficient table.
module polyphase_interpolator_by_two_core #(
    parameter int TAPS       = pi2_pkg::TAPS_DEF,
    parameter int COEF_WIDTH = pi2_pkg::COEF_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [pi2_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [pi2_pkg::SAMPLE_W-1:0] o_first_sample,
    output logic signed [pi2_pkg::SAMPLE_W-1:0] o_second_sample
);
    import pi2_pkg::*;

    localparam int HALF   = TAPS / 2;
    localparam int PTR_W  = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int FRAC   = COEF_WIDTH - 2;
    localparam int PROD_W = COEF_WIDTH + DIGIT_W + 1;
    localparam int ACC_W  = COEF_WIDTH + SAMPLE_W + PTR_W + 2;
    localparam int DCNT_W = $clog2(NUM_DIGITS);

    localparam logic [PTR_W-1:0]         LAST_PTR = PTR_W'(HALF - 1);
    localparam logic [DCNT_W-1:0]        LAST_DIG = DCNT_W'(NUM_DIGITS - 1);
    localparam logic signed [ACC_W-1:0]  RND_HALF = ACC_W'(1) <<< (FRAC - 1);
    localparam logic signed [ACC_W-1:0]  POS_LIM  = ACC_W'(SAT_MAX);
    localparam logic signed [ACC_W-1:0]  NEG_LIM  = -ACC_W'(SAT_MAX);

    // Delay line memory and per-entry valid bits
    logic signed [SAMPLE_W-1:0] r_line [HALF];
    logic [HALF-1:0]            r_line_vld;

    t_state                      r_state;
    logic [PTR_W-1:0]            r_wp;
    logic [PTR_W-1:0]            r_rp;
    logic [PTR_W-1:0]            r_tap;
    logic [DCNT_W-1:0]           r_dig;
    logic signed [SAMPLE_W-1:0]  r_x;
    logic signed [COEF_WIDTH-1:0] r_ce;
    logic signed [COEF_WIDTH-1:0] r_co;
    logic signed [ACC_W-1:0]     r_acc_e;
    logic signed [ACC_W-1:0]     r_acc_o;
    logic                        r_o_valid;
    logic signed [SAMPLE_W-1:0]  r_out_e;
    logic signed [SAMPLE_W-1:0]  r_out_o;

    logic                        in_xact;
    logic                        out_xact;
    logic                        out_free;
    logic [PTR_W-1:0]            n_wp;
    logic signed [SAMPLE_W-1:0]  clamp_x;
    logic signed [DIGIT_W:0]     digit;
    logic signed [PROD_W-1:0]    prod_e;
    logic signed [PROD_W-1:0]    prod_o;
    logic signed [ACC_W-1:0]     n_acc_e;
    logic signed [ACC_W-1:0]     n_acc_o;
    logic signed [ACC_W-1:0]     rnd_e;
    logic signed [ACC_W-1:0]     rnd_o;
    logic signed [ACC_W-1:0]     q_e;
    logic signed [ACC_W-1:0]     q_o;
    logic signed [SAMPLE_W-1:0]  sat_e;
    logic signed [SAMPLE_W-1:0]  sat_o;

    assign o_ready         = (r_state == S_IDLE);
    assign in_xact         = i_valid && o_ready;
    assign out_xact        = r_o_valid && i_ready;
    assign out_free        = !r_o_valid || i_ready;
    assign o_valid         = r_o_valid;
    assign o_first_sample  = r_out_e;
    assign o_second_sample = r_out_o;

    // Advance the write pointer with wrap, fold the most negative code
    assign n_wp    = (r_wp == LAST_PTR) ? '0 : r_wp + PTR_W'(1);
    assign clamp_x = (i_sample == {1'b1, {(SAMPLE_W-1){1'b0}}}) ?
                     -SAMPLE_W'(SAT_MAX) : i_sample;

    // Digit-serial multiply: low digits unsigned, top digit carries the sign
    always_comb begin
        if (r_dig == LAST_DIG) begin
            digit = {r_x[DIGIT_W-1], r_x[DIGIT_W-1:0]};
        end else begin
            digit = {1'b0, r_x[DIGIT_W-1:0]};
        end
        prod_e  = PROD_W'(r_ce) * PROD_W'(digit);
        prod_o  = PROD_W'(r_co) * PROD_W'(digit);
        n_acc_e = r_acc_e + (ACC_W'(prod_e) <<< (DIGIT_W * r_dig));
        n_acc_o = r_acc_o + (ACC_W'(prod_o) <<< (DIGIT_W * r_dig));
    end

    // Round to nearest (ties away from zero) and saturate
    always_comb begin
        rnd_e = r_acc_e + (r_acc_e[ACC_W-1] ? RND_HALF - ACC_W'(1) : RND_HALF);
        rnd_o = r_acc_o + (r_acc_o[ACC_W-1] ? RND_HALF - ACC_W'(1) : RND_HALF);
        q_e   = rnd_e >>> FRAC;
        q_o   = rnd_o >>> FRAC;
        if (q_e > POS_LIM) begin
            sat_e = SAMPLE_W'(SAT_MAX);
        end else if (q_e < NEG_LIM) begin
            sat_e = -SAMPLE_W'(SAT_MAX);
        end else begin
            sat_e = q_e[SAMPLE_W-1:0];
        end
        if (q_o > POS_LIM) begin
            sat_o = SAMPLE_W'(SAT_MAX);
        end else if (q_o < NEG_LIM) begin
            sat_o = -SAMPLE_W'(SAT_MAX);
        end else begin
            sat_o = q_o[SAMPLE_W-1:0];
        end
    end

    // Write the new sample into the delay line
    always_ff @(posedge i_clk) begin
        if (in_xact) begin
            r_line[n_wp] <= clamp_x;
        end
    end

    // Track which line entries hold a written sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_vld <= '0;
        end else if (in_xact) begin
            r_line_vld[n_wp] <= 1'b1;
        end
    end

    // Registered line read and coefficient fetch for the current tap
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            r_x  <= r_line_vld[r_rp] ? r_line[r_rp] : '0;
            r_ce <= COEF_WIDTH'(coef_at(2 * int'(r_tap), COEF_WIDTH));
            r_co <= COEF_WIDTH'(coef_at(2 * int'(r_tap) + 1, COEF_WIDTH));
        end else if (r_state == S_MAC) begin
            r_x <= r_x >>> DIGIT_W;
        end
    end

    // Accumulators: clear on a new transaction, add one digit product a cycle in the multiply state
    always_ff @(posedge i_clk) begin
        if (in_xact) begin
            r_acc_e <= '0;
            r_acc_o <= '0;
        end else if (r_state == S_MAC) begin
            r_acc_e <= n_acc_e;
            r_acc_o <= n_acc_o;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_e <= sat_e;
            r_out_o <= sat_o;
        end
    end

    // Sequencer: one line read, then one multiply per sample digit, per tap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wp      <= LAST_PTR;
            r_rp      <= '0;
            r_tap     <= '0;
            r_dig     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // Raise valid as the walk finishes, drop it once the result is taken
            if (r_state == S_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (out_xact) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xact) begin
                        r_wp    <= n_wp;
                        r_rp    <= n_wp;
                        r_tap   <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_dig   <= '0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    r_dig <= r_dig + DCNT_W'(1);
                    if (r_dig == LAST_DIG) begin
                        if (r_tap == LAST_PTR) begin
                            r_state <= S_DONE;
                        end else begin
                            r_tap   <= r_tap + PTR_W'(1);
                            r_rp    <= (r_rp == '0) ? LAST_PTR : r_rp - PTR_W'(1);
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // An input transaction always starts a tap walk
    a_start_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xact |=> (r_state == S_LOAD))
        else $error("tap walk did not start after input transaction");

    // A new result appears only when the walk finishes
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == S_DONE))
        else $error("output valid rose outside the finishing state");

    // Write pointer moves only on an input transaction
    a_wp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_xact |=> $stable(r_wp))
        else $error("write pointer moved without an input transaction");

    // Saturated results never reach the most negative code
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_out_e != {1'b1, {(SAMPLE_W-1){1'b0}}}) &&
                      (r_out_o != {1'b1, {(SAMPLE_W-1){1'b0}}}))
        else $error("output outside saturation range");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for polyphase_interpolator_by_two_core at default sizes.
// Runs directed and random samples through a valid/ready handshake and checks both phases.
// Depends on pi2_pkg and polyphase_interpolator_by_two_core.
module testbench;

    import pi2_pkg::*;

    localparam int HALF_LEN     = TAPS_DEF / 2;
    localparam int FRAC_BITS    = COEF_WIDTH_DEF - 2;
    localparam int LATENCY      = 5 * TAPS_DEF / 2 + 1;
    localparam int DRAIN_CYCLES = 4 * LATENCY;
    localparam int HOLD_CYCLES  = 600;
    localparam int STALL_LIMIT  = 5000;

    // Low-pass prototype in Q2.16, even phase at even indexes
    localparam int FIR_COEF [TAPS_DEF] = '{
        0, -8, 34, 88, -183, -338, 576, 930,
        -1439, -2158, 3171, 4628, -6840, -10614, 18934, 58753,
        58753, 18934, -10614, -6840, 4628, 3171, -2158, -1439,
        930, 576, -338, -183, 88, 34, -8, 0
    };

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] even_smp;
        logic signed [SAMPLE_W-1:0] odd_smp;
    } t_out_pair;

    logic                       i_clk   = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       i_ready = 1'b0;
    logic                       o_ready;
    logic                       o_valid;
    logic signed [SAMPLE_W-1:0] o_first_sample;
    logic signed [SAMPLE_W-1:0] o_second_sample;

    // Predictor state: delay line and index of the newest entry
    logic signed [SAMPLE_W-1:0] line_mem [HALF_LEN];
    logic [3:0]                 newest_idx;

    t_out_pair expected_q [$];
    t_out_pair exp_pair;
    int        error_count = 0;
    int        quiet_cycles = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_requests = 0;
    int        hold_served = 0;
    int        hold_left = 0;

    polyphase_interpolator_by_two_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample        (i_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_first_sample  (o_first_sample),
        .o_second_sample (o_second_sample)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Convolve the line with one phase, round half away from zero, saturate
    function automatic logic signed [SAMPLE_W-1:0] phase_sum(input int phase);
        longint acc;
        longint q;
        int     d;
        acc = 0;
        for (d = 0; d < HALF_LEN; d++) begin
            acc += longint'(FIR_COEF[2 * d + phase])
                 * longint'(line_mem[4'(newest_idx - 4'(d))]);
        end
        if (acc >= 0) begin
            q = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        end else begin
            q = -((-acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        end
        if (q > SAT_MAX) q = SAT_MAX;
        if (q < -SAT_MAX) q = -SAT_MAX;
        return 16'(q);
    endfunction

    // Push one low-rate sample and compute the two high-rate outputs
    task automatic push_and_filter(input logic signed [SAMPLE_W-1:0] smp,
                                   output t_out_pair res);
        logic signed [SAMPLE_W-1:0] x;
        x = (smp == -16'sd32768) ? -16'sd32767 : smp;
        newest_idx = newest_idx + 4'd1;
        line_mem[newest_idx] = x;
        res.even_smp = phase_sum(0);
        res.odd_smp  = phase_sum(1);
    endtask

    // Offer one sample, wait for the transaction, record the expected pair
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
        t_out_pair res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= smp;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        push_and_filter(smp, res);
        expected_q.push_back(res);
    endtask

    // Sample matched to the coefficient signs, so one phase lands at full scale
    function automatic logic signed [SAMPLE_W-1:0] sign_matched(input int pos, input int phase,
                                                               input int pol, input int mag);
        int c;
        c = FIR_COEF[2 * (HALF_LEN - 1 - pos) + phase];
        return (c < 0) ? 16'(-pol * mag) : 16'(pol * mag);
    endfunction

    // Mixed random traffic: uniform, extremes, full-scale sign runs, tiny values
    task automatic run_random_items(input int count);
        int sent;
        int mode;
        int run;
        int k;
        int pol;
        int phase;
        int mag;
        sent = 0;
        while (sent < count) begin
            mode = $urandom_range(0, 9);
            run  = (mode < 7) ? $urandom_range(1, 30) : HALF_LEN;
            if (run > count - sent) run = count - sent;
            pol   = $urandom_range(0, 1) ? 1 : -1;
            phase = $urandom_range(0, 1);
            for (k = 0; k < run; k++) begin
                if (mode < 5) begin
                    send_sample(16'($urandom_range(0, 65535)));
                end else if (mode < 6) begin
                    case ($urandom_range(0, 5))
                        0: send_sample(16'sd32767);
                        1: send_sample(-16'sd32768);
                        2: send_sample(-16'sd32767);
                        3: send_sample(16'sd0);
                        4: send_sample(16'sd1);
                        default: send_sample(-16'sd1);
                    endcase
                end else if (mode < 7) begin
                    send_sample(16'($signed($urandom_range(0, 8)) - 4));
                end else begin
                    mag = $urandom_range(0, 3) == 0 ? 32768 : $urandom_range(20000, 32767);
                    send_sample(sign_matched(k, phase, pol, mag));
                end
            end
            sent += run;
        end
    endtask

    task automatic test_extremes;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(-16'sd32767);
        send_sample(16'sd0);
        send_sample(16'sd1);
        send_sample(-16'sd1);
    endtask

    // Full-scale run of the most negative code (a magnitude of 32768 wraps to it for either sign)
    task automatic test_saturation;
        int k;
        for (k = 0; k < HALF_LEN; k++) begin
            send_sample(sign_matched(k, 0, 1, 32768));
        end
    endtask

    task automatic test_no_idle;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_items(260);
    endtask

    task automatic test_sender_idle;
        send_idle_pct  = 52;
        recv_stall_pct = 0;
        run_random_items(260);
    endtask

    task automatic test_receiver_stall;
        send_idle_pct  = 0;
        recv_stall_pct = 52;
        run_random_items(260);
    endtask

    task automatic test_both_idle;
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        run_random_items(260);
    endtask

    // Hold the output side off while the sender keeps offering samples
    task automatic test_output_hold_off;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests <= hold_requests + 1;
        run_random_items(88);
    endtask

    // Receiver: random stalls, plus one long counted hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_ready     <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare each output transaction with the oldest expected pair
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                $error("output transaction with nothing expected: first %0d second %0d",
                       o_first_sample, o_second_sample);
                error_count++;
            end else begin
                exp_pair = expected_q.pop_front();
                if (o_first_sample !== exp_pair.even_smp) begin
                    $error("first_sample: expected %0d, got %0d",
                           exp_pair.even_smp, o_first_sample);
                    error_count++;
                end
                if (o_second_sample !== exp_pair.odd_smp) begin
                    $error("second_sample: expected %0d, got %0d",
                           exp_pair.odd_smp, o_second_sample);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int k;
        for (k = 0; k < HALF_LEN; k++) line_mem[k] = '0;
        newest_idx = 4'(HALF_LEN - 1);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_saturation();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_output_hold_off();

        // Drain: wait out every expected pair, then look for strays
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
